>>> hw/rtl/rescale_mul_div_64x32_assert.svh
// Assertion macros shared by the rescale multiply-divide RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef RESCALE_MUL_DIV_64X32_ASSERT_SVH
`define RESCALE_MUL_DIV_64X32_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmd assertion failed");

`endif

>>> hw/rtl/rmd_pkg.sv
// Types and constants for the rescale multiply-divide block.
// Depends on nothing; used by every module of the block.
package rmd_pkg;

    // Number of restoring-division cells, one per quotient bit.
    localparam int unsigned RMD_CELLS = 64;
    // Front end takes three register stages, the output register one more.
    localparam int unsigned RMD_LATENCY = RMD_CELLS + 4;

    localparam logic [63:0] RMD_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] RMD_ONE = 64'd1;

    // One input item.
    typedef struct packed {
        logic        action;
        logic [63:0] dividend;
        logic [31:0] multiplier;
        logic [31:0] divisor;
    } rmd_in_t;

    // One result item.
    typedef struct packed {
        logic [63:0] quotient;
        logic        overflow;
    } rmd_out_t;

    // Data carried from cell to cell along the division chain.
    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [31:0] divisor;
        logic [31:0] rem;
        logic [63:0] bits;
    } rmd_cell_t;

endpackage

>>> hw/rtl/rmd_mul.sv
// Front end: sign handling, 64x32 product as two 32x32 halves, overflow test.
// Depends on rmd_pkg; feeds the first division cell.
module rmd_mul
    import rmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  rmd_in_t   in_item,
    output logic      out_valid,
    output rmd_cell_t out_cell
);

    logic        a_valid_reg;
    logic        a_neg_reg;
    logic [63:0] a_mag_reg;
    logic [31:0] a_mul_reg;
    logic [31:0] a_div_reg;

    logic        b_valid_reg;
    logic        b_neg_reg;
    logic [63:0] b_lo_reg;
    logic [63:0] b_hi_reg;
    logic [31:0] b_div_reg;

    logic        c_valid_reg;
    rmd_cell_t   c_cell_reg;

    logic        neg_next;
    logic [63:0] mag_next;
    logic [95:0] prod_next;

    // A negative signed dividend is replaced by its magnitude.
    always_comb
    begin
        neg_next = in_item.action & in_item.dividend[63];
        mag_next = neg_next ? (64'd0 - in_item.dividend) : in_item.dividend;
    end

    // Full product from the two partial products.
    assign prod_next = {b_hi_reg, 32'd0} + {32'd0, b_lo_reg};

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge clk)
    begin
        a_neg_reg <= neg_next;
        a_mag_reg <= mag_next;
        a_mul_reg <= in_item.multiplier;
        a_div_reg <= in_item.divisor;

        b_neg_reg <= a_neg_reg;
        b_lo_reg  <= 64'(a_mag_reg[31:0]) * 64'(a_mul_reg);
        b_hi_reg  <= 64'(a_mag_reg[63:32]) * 64'(a_mul_reg);
        b_div_reg <= a_div_reg;

        c_cell_reg.neg     <= b_neg_reg;
        c_cell_reg.ovf     <= (prod_next[95:64] >= b_div_reg);
        c_cell_reg.divisor <= b_div_reg;
        c_cell_reg.rem     <= prod_next[95:64];
        c_cell_reg.bits    <= prod_next[63:0];
    end

    assign out_valid = c_valid_reg;
    assign out_cell  = c_cell_reg;

endmodule

>>> hw/rtl/rmd_div_cell.sv
// One restoring-division cell: produces one quotient bit per item and passes it on.
// Depends on rmd_pkg and the assertion macro header.
`include "rescale_mul_div_64x32_assert.svh"

module rmd_div_cell
    import rmd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  rmd_cell_t in_cell,
    output logic      out_valid,
    output rmd_cell_t out_cell
);

    logic        valid_reg;
    rmd_cell_t   cell_reg;
    rmd_cell_t   cell_next;
    logic [32:0] trial;
    logic [31:0] diff;
    logic        ge;

    // Bring down the next dividend bit and subtract the divisor if it fits.
    // When it fits the difference is below the divisor, so 32 bits hold it.
    always_comb
    begin
        trial = {in_cell.rem, in_cell.bits[63]};
        diff  = trial[31:0] - in_cell.divisor;
        ge    = (trial >= {1'b0, in_cell.divisor});

        cell_next      = in_cell;
        cell_next.rem  = ge ? diff : trial[31:0];
        cell_next.bits = {in_cell.bits[62:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

    // The partial remainder stays below the divisor for items that did not overflow.
    `RMD_ASSERT_IMPLIES(a_rem_bound, clk, rst_n, valid_reg && !cell_reg.ovf,
        cell_reg.rem < cell_reg.divisor)
    // An item moves one cell per cycle.
    `RMD_ASSERT_NEXT(a_valid_moves, clk, rst_n, in_valid, valid_reg)
    // The divisor and the sign flag travel with their item unchanged.
    `RMD_ASSERT_NEXT(a_divisor_kept, clk, rst_n, in_valid,
        cell_reg.divisor == $past(in_cell.divisor) && cell_reg.neg == $past(in_cell.neg))

endmodule

>>> hw/rtl/rescale_mul_div_64x32.sv
// Top level of the rescale multiply-divide block: front end, division chain, output.
// Depends on rmd_pkg, rmd_mul, rmd_div_cell and the assertion macro header.
`include "rescale_mul_div_64x32_assert.svh"

// Computes dividend * multiplier / divisor, rounded toward zero, with a 96-bit
// exact product. An item is taken whenever start is high; busy is always low,
// so one item enters every cycle. Each result appears on result for one cycle
// with done high, after its item has passed three front-end stages (sign,
// two 32x32 multiplies, the 96-bit sum and overflow compare), a chain of 64
// division cells that each produce one quotient bit, and the output register.
// The receiver cannot stall, so results must be taken as they come. Overflow
// (upper product word not below divisor, including a zero divisor) gives all
// ones, or 1 when a negative signed dividend was negated.
module rescale_mul_div_64x32
    import rmd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rmd_in_t  req,
    output logic     done,
    output rmd_out_t result
);

    logic      accepted;
    logic      chain_valid [RMD_CELLS+1];
    rmd_cell_t chain_cell  [RMD_CELLS+1];

    logic      done_reg;
    rmd_out_t  result_reg;
    rmd_out_t  result_next;
    logic [63:0] q_raw;

    // The pipeline takes a new item in every cycle.
    assign busy     = 1'b0;
    assign accepted = start & ~busy;

    // Sign handling, product and overflow test.
    rmd_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accepted),
        .in_item   (req),
        .out_valid (chain_valid[0]),
        .out_cell  (chain_cell[0])
    );

    // Division chain, one quotient bit per cell.
    for (genvar i = 0; i < RMD_CELLS; i++)
    begin : g_cell
        rmd_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_cell   (chain_cell[i]),
            .out_valid (chain_valid[i+1]),
            .out_cell  (chain_cell[i+1])
        );
    end

    // Overflow substitution and sign restore.
    always_comb
    begin
        q_raw = chain_cell[RMD_CELLS].ovf ? RMD_ALL_ONES : chain_cell[RMD_CELLS].bits;
        result_next.quotient = chain_cell[RMD_CELLS].neg ? (64'd0 - q_raw) : q_raw;
        result_next.overflow = chain_cell[RMD_CELLS].ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[RMD_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every result belongs to an item taken a fixed latency earlier.
    `RMD_ASSERT_IMPLIES(a_done_latency, clk, rst_n, done,
        $past(accepted, RMD_LATENCY))
    // An overflowing item gives all ones, or one after sign restore.
    `RMD_ASSERT_IMPLIES(a_ovf_value, clk, rst_n, done && result.overflow,
        result.quotient == RMD_ALL_ONES || result.quotient == RMD_ONE)
    // A zero divisor always ends in overflow.
    `RMD_ASSERT_IMPLIES(a_zero_div, clk, rst_n,
        done && $past(accepted && req.divisor == 32'd0, RMD_LATENCY), result.overflow)

endmodule

>>> tb/sv/tb_rescale_mul_div_64x32.sv
`timescale 1ns / 1ps
// Self-checking testbench for rescale_mul_div_64x32: dividend * multiplier / divisor, rounded toward zero.
// Depends on rmd_pkg and the block's RTL; needs no files or arguments at run time.

module tb_rescale_mul_div_64x32
    import rmd_pkg::*;
();

    // Interpretation of the dividend.
    localparam logic ACT_UNSIGNED = 1'b0;
    localparam logic ACT_SIGNED   = 1'b1;

    // Generous run limit, many times the slowest correct run.
    localparam int unsigned CYCLE_LIMIT = 100000;

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    rmd_in_t  req;
    logic     done;
    rmd_out_t result;

    // Expected results, oldest first.
    rmd_out_t    quotient_queue[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;

    rescale_mul_div_64x32 i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    // Free-running 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Exact 96-bit product, divided by the divisor; negative signed dividends are
    // rescaled by magnitude and the result is negated modulo 2^64.
    function automatic rmd_out_t scaled_quotient(rmd_in_t item);
        logic        negate;
        logic [63:0] magnitude;
        logic [95:0] product;
        logic [95:0] ratio;
        rmd_out_t    res;
        negate    = (item.action == ACT_SIGNED) && item.dividend[63];
        magnitude = negate ? (64'd0 - item.dividend) : item.dividend;
        product   = {32'd0, magnitude} * {64'd0, item.multiplier};
        if (product[95:64] >= item.divisor)
        begin
            res.quotient = RMD_ALL_ONES;
            res.overflow = 1'b1;
        end
        else
        begin
            ratio        = product / {64'd0, item.divisor};
            res.quotient = ratio[63:0];
            res.overflow = 1'b0;
        end
        if (negate)
            res.quotient = 64'd0 - res.quotient;
        return res;
    endfunction

    // Dividend drawn from a mix of edge values and full-range random bits.
    function automatic logic [63:0] pick_dividend();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return RMD_ALL_ONES;
            2: return RMD_ONE;
            3: return MOST_NEG;
            4: return MOST_POS;
            5: return {32'd0, $urandom};
            6: return 64'd0 - {54'd0, 10'($urandom_range(1, 1000))};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Multiplier or divisor drawn the same way at 32 bits.
    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return MAX32;
            2: return 32'd1;
            3: return 32'($urandom_range(2, 255));
            4: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic rmd_in_t random_item();
        rmd_in_t item;
        item.action     = $urandom_range(0, 1) ? ACT_SIGNED : ACT_UNSIGNED;
        item.dividend   = pick_dividend();
        item.multiplier = pick_scale();
        item.divisor    = pick_scale();
        // Now and then sit right on the overflow boundary.
        if ($urandom_range(0, 7) == 0)
            item.multiplier = item.divisor + 32'($urandom_range(0, 1));
        return item;
    endfunction

    // Offers one item and holds it until the block takes it. Called just after a
    // rising edge; returns just after the edge that accepted the item.
    task automatic send_item(input rmd_in_t item);
        logic taken;
        req   <= item;
        start <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic idle_cycles(input int unsigned count);
        if (count > 0)
        begin
            start <= 1'b0;
            repeat (count) @(posedge clk);
        end
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        @(negedge clk);
        while (quotient_queue.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Field extremes, both modes, zero divisor, the overflow boundary, the
    // negated overflow, the most negative dividend and large signed results.
    task automatic test_directed();
        send_item(rmd_in_t'{ACT_UNSIGNED, 64'd0, 32'd0, 32'd0});
        send_item(rmd_in_t'{ACT_UNSIGNED, 64'd0, MAX32, 32'd1});
        send_item(rmd_in_t'{ACT_UNSIGNED, RMD_ALL_ONES, MAX32, MAX32});
        send_item(rmd_in_t'{ACT_UNSIGNED, RMD_ALL_ONES, 32'd1, 32'd1});
        send_item(rmd_in_t'{ACT_UNSIGNED, RMD_ALL_ONES, 32'd2, 32'd1});
        send_item(rmd_in_t'{ACT_UNSIGNED, 64'd12345, 32'd7, 32'd0});
        send_item(rmd_in_t'{ACT_SIGNED, RMD_ALL_ONES, 32'd3, 32'd2});
        send_item(rmd_in_t'{ACT_SIGNED, RMD_ALL_ONES, 32'd5, 32'd0});
        send_item(rmd_in_t'{ACT_SIGNED, MOST_NEG, 32'd1, 32'd1});
        send_item(rmd_in_t'{ACT_SIGNED, MOST_NEG, 32'd2, 32'd1});
        send_item(rmd_in_t'{ACT_SIGNED, MOST_NEG, 32'd3, 32'd4});
        send_item(rmd_in_t'{ACT_SIGNED, MOST_POS, 32'd2, 32'd1});
        send_item(rmd_in_t'{ACT_SIGNED, MOST_POS, MAX32, MAX32});
        send_item(rmd_in_t'{ACT_UNSIGNED, RMD_ALL_ONES, 32'hDEAD_BEEF, 32'hDEAD_BEEF});
        send_item(rmd_in_t'{ACT_UNSIGNED, RMD_ALL_ONES, 32'hDEAD_BEF0, 32'hDEAD_BEEF});
        send_item(rmd_in_t'{ACT_SIGNED, 64'd0 - 64'd1000, 32'd0, 32'd7});
        send_item(rmd_in_t'{ACT_UNSIGNED, 64'h0123_4567_89AB_CDEF, 32'h9E37_79B9,
                            32'h7FFF_FFFF});
        send_item(rmd_in_t'{ACT_SIGNED, 64'hFEDC_BA98_7654_3210, 32'h1234_5678,
                            32'h8765_4321});
        send_item(rmd_in_t'{ACT_UNSIGNED, RMD_ONE, 32'd1, MAX32});
        send_item(rmd_in_t'{ACT_UNSIGNED, 64'hFFFF_FFFF_0000_0000, MAX32, 32'h8000_0000});
        send_item(rmd_in_t'{ACT_SIGNED, RMD_ONE, MAX32, 32'd1});
        send_item(rmd_in_t'{ACT_SIGNED, MOST_NEG, MAX32, MAX32});
    endtask

    // Random items offered on every cycle with no gaps.
    task automatic test_back_to_back(input int unsigned count);
        repeat (count)
            send_item(random_item());
    endtask

    // Random items in bursts of random length, with random gaps or none at all.
    task automatic test_random_bursts(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned k;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < count; k++)
            begin
                send_item(random_item());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 10));
        end
    endtask

    // Record each accepted item's expectation and check each strobed result.
    always @(posedge clk)
    begin
        rmd_out_t want;
        if (rst_n)
        begin
            if (start && !busy)
                quotient_queue.push_back(scaled_quotient(req));
            if (done)
            begin
                if (quotient_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: quotient %h overflow %b",
                                 result.quotient, result.overflow);
                end
                else
                begin
                    want = quotient_queue.pop_front();
                    if (result.quotient !== want.quotient
                        || result.overflow !== want.overflow)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected quotient %h overflow %b, got %h %b",
                                     want.quotient, want.overflow,
                                     result.quotient, result.overflow);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Reset once, then run the tests in turn and report.
    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_for_results();
        test_back_to_back(40);
        wait_for_results();
        test_random_bursts(390);
        wait_for_results();

        // Catch any stray strobe after the last expected result.
        repeat (RMD_LATENCY + 8) @(posedge clk);

        if (mismatch_count == 0 && quotient_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
